// File: rtl/core/media_timestamp_normalizer_macros.svh
// Assertion macros for the media timestamp normalizer.
// Included by RTL files that carry concurrent assertions; no other dependencies.
`ifndef MEDIA_TIMESTAMP_NORMALIZER_MACROS_SVH
`define MEDIA_TIMESTAMP_NORMALIZER_MACROS_SVH

`ifndef SYNTHESIS

`define MTN_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

`define MTN_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`else

`define MTN_ASSERT_NOW(lbl, clk, rst, ante, cons, msg)

`define MTN_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)

`endif

`endif

// File: rtl/core/mtn_pkg.sv
// Shared types and constants for the media timestamp normalizer.
// No dependencies.
`default_nettype none

package mtn_pkg;

  localparam int unsigned TS_W      = 64;
  localparam int unsigned CFG_W     = 32;
  localparam int unsigned APB_ADDR_W = 3;
  localparam int unsigned DATA_W    = 136;

  localparam logic [CFG_W-1:0] JUMP_THRESHOLD_RESET = 32'd180000;
  localparam logic [CFG_W-1:0] GUARD_GAP_RESET      = 32'd3000;

  typedef enum logic [0:0] {
    REG_JUMP_THRESHOLD = 1'b0,
    REG_GUARD_GAP      = 1'b1
  } reg_index_t;

  typedef enum logic [1:0] {
    CORR_NONE = 2'd0,
    CORR_BUMP = 2'd1,
    CORR_SNAP = 2'd2
  } corr_t;

endpackage

`default_nettype wire

// File: rtl/core/media_timestamp_normalizer.sv
// Media timestamp normalizer: per-stream monotonic DTS/PTS guard.
// Pipeline: a transaction passes through the input register, then the result register.
// Throughput: one transaction per cycle unless m_tready stalls; per-stream state is read
// and updated in the same cycle, so consecutive packets of one stream follow back to back.
// Reset (rst, synchronous, active high) clears the per-stream seen flags and jump offsets,
// both pipeline valids and restores jump_threshold to 180000 and guard_gap to 3000.
`default_nettype none

`include "media_timestamp_normalizer_macros.svh"

module media_timestamp_normalizer
  import mtn_pkg::*;
#(
  parameter int NUM_STREAMS = 2
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  // [0] dts_in_valid, [64:1] dts_in, [65] pts_in_valid, [129:66] pts_in, rest zero
  input  wire logic [DATA_W-1:0]     s_tdata,
  // [0] stream
  input  wire logic [0:0]            s_tuser,
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  // [0] dts_out_valid, [64:1] dts_out, [65] pts_out_valid, [129:66] pts_out,
  // [131:130] correction, rest zero
  output logic [DATA_W-1:0]          m_tdata,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [APB_ADDR_W-1:0] paddr,
  input  wire logic [CFG_W-1:0]      pwdata,
  output logic [CFG_W-1:0]           prdata,
  output logic                       pready
);

  localparam int SW = (NUM_STREAMS > 1) ? $clog2(NUM_STREAMS) : 1;

  logic [CFG_W-1:0] jump_threshold;
  logic [CFG_W-1:0] guard_gap;

  logic [TS_W-1:0] first_dts [NUM_STREAMS];
  logic [TS_W-1:0] first_pts [NUM_STREAMS];
  logic [TS_W-1:0] last_dts [NUM_STREAMS];
  logic [TS_W-1:0] jump_offset [NUM_STREAMS];
  logic [NUM_STREAMS-1:0] first_dts_seen;
  logic [NUM_STREAMS-1:0] first_pts_seen;
  logic [NUM_STREAMS-1:0] last_dts_seen;

  logic            in_valid;
  logic            in_stream;
  logic            in_dv;
  logic [TS_W-1:0] in_dts;
  logic            in_pv;
  logic [TS_W-1:0] in_pts;

  logic            out_valid;
  logic            out_dv;
  logic [TS_W-1:0] out_dts;
  logic            out_pv;
  logic [TS_W-1:0] out_pts;
  corr_t           out_corr;

  logic            advance;
  logic            cfg_write;
  logic [SW-1:0]   idx;
  logic            in_range;
  logic            dv;
  logic [TS_W-1:0] dts_sel;
  logic [TS_W-1:0] dts_base;
  logic [TS_W-1:0] pts_base;
  logic [TS_W-1:0] dts_adj;
  logic [TS_W-1:0] pts_adj;
  logic [TS_W-1:0] delta;
  logic [TS_W-1:0] gap;
  logic            nonpos;
  logic            snap;
  logic            dv_next;
  logic [TS_W-1:0] dts_next;
  logic            pv_next;
  logic [TS_W-1:0] pts_next;
  corr_t           corr_next;
  logic            upd;

  assign advance   = !out_valid || m_tready;
  assign s_tready  = !in_valid || advance;
  assign cfg_write = psel && penable && pwrite && pready;
  assign pready    = 1'b1;

  always_comb begin
    case (reg_index_t'(paddr[2]))
      REG_JUMP_THRESHOLD: prdata = jump_threshold;
      REG_GUARD_GAP:      prdata = guard_gap;
      default:            prdata = '0;
    endcase
  end

  always_comb begin
    idx      = SW'(in_stream);
    in_range = (NUM_STREAMS > 1) || (in_stream == 1'b0);
    dv       = in_dv || in_pv;
    dts_sel  = in_dv ? in_dts : in_pts;
    dts_base = dts_sel - (first_dts_seen[idx] ? first_dts[idx] : dts_sel);
    pts_base = in_pts - (first_pts_seen[idx] ? first_pts[idx] : in_pts);
    dts_adj  = dts_base - jump_offset[idx];
    pts_adj  = pts_base - jump_offset[idx];
    delta    = dts_adj - last_dts[idx];
    gap      = delta - {{(TS_W-CFG_W){1'b0}}, guard_gap};
    nonpos   = (delta == '0) || delta[TS_W-1];
    snap     = !nonpos && (delta > {{(TS_W-CFG_W){1'b0}}, jump_threshold});

    dts_next  = dts_adj;
    pts_next  = dv ? pts_adj : pts_base;
    corr_next = CORR_NONE;
    if (dv && last_dts_seen[idx]) begin
      if (nonpos) begin
        dts_next  = last_dts[idx] + TS_W'(1);
        pts_next  = pts_adj - delta + TS_W'(1);
        corr_next = CORR_BUMP;
      end else if (snap) begin
        dts_next  = dts_adj - gap;
        pts_next  = pts_adj - gap;
        corr_next = CORR_SNAP;
      end
    end
    dv_next = dv && in_range;
    pv_next = in_pv && in_range;
    if (!dv_next) begin
      dts_next = '0;
    end
    if (!pv_next) begin
      pts_next = '0;
    end
    if (!in_range) begin
      corr_next = CORR_NONE;
    end
    upd = in_valid && advance && in_range;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      jump_threshold <= JUMP_THRESHOLD_RESET;
      guard_gap      <= GUARD_GAP_RESET;
      in_valid       <= 1'b0;
      out_valid      <= 1'b0;
      first_dts_seen <= '0;
      first_pts_seen <= '0;
      last_dts_seen  <= '0;
      for (int i = 0; i < NUM_STREAMS; i++) begin
        jump_offset[i] <= '0;
      end
    end else begin
      if (cfg_write) begin
        case (reg_index_t'(paddr[2]))
          REG_JUMP_THRESHOLD: jump_threshold <= pwdata;
          REG_GUARD_GAP:      guard_gap <= pwdata;
          default:            ;
        endcase
      end
      if (s_tready) begin
        in_valid <= s_tvalid;
      end
      if (advance) begin
        out_valid <= in_valid;
      end
      if (upd && dv) begin
        if (!first_dts_seen[idx]) begin
          first_dts[idx]      <= dts_sel;
          first_dts_seen[idx] <= 1'b1;
        end
        last_dts[idx]      <= dts_next;
        last_dts_seen[idx] <= 1'b1;
        if (corr_next == CORR_SNAP) begin
          jump_offset[idx] <= jump_offset[idx] + gap;
        end
      end
      if (upd && in_pv && !first_pts_seen[idx]) begin
        first_pts[idx]      <= in_pts;
        first_pts_seen[idx] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_stream <= s_tuser[0];
      in_dv     <= s_tdata[0];
      in_dts    <= s_tdata[64:1];
      in_pv     <= s_tdata[65];
      in_pts    <= s_tdata[129:66];
    end
    if (advance && in_valid) begin
      out_dv   <= dv_next;
      out_dts  <= dts_next;
      out_pv   <= pv_next;
      out_pts  <= pts_next;
      out_corr <= corr_next;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {4'b0, out_corr, out_pts, out_pv, out_dts, out_dv};

  `MTN_ASSERT_NOW(a_pts_implies_dts, clk, rst, out_valid && out_pv, out_dv,
    "result carries a PTS without a DTS")
  `MTN_ASSERT_NOW(a_corr_needs_dts, clk, rst, out_valid && (out_corr != CORR_NONE), out_dv,
    "correction reported without a DTS")
  `MTN_ASSERT_NOW(a_absent_dts_zero, clk, rst, out_valid && !out_dv, out_dts == '0,
    "absent DTS is not zero")
  `MTN_ASSERT_NEXT(a_stage_holds, clk, rst, in_valid && !advance, in_valid,
    "input stage dropped a transaction while the result was stalled")
  `MTN_ASSERT_NEXT(a_bump_monotonic, clk, rst,
    upd && dv && (corr_next == CORR_BUMP), last_dts[$past(idx)] == $past(last_dts[idx]) + 64'd1,
    "bumped DTS is not previous plus one")

endmodule

`default_nettype wire
